[design/ps2mc_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mc_pkg
// Types and constants for the PS/2 mouse packet decoder with clamped cursor.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DxW      = 9;
  localparam int unsigned DyW      = 10;
  localparam int unsigned SumW     = 14;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ByteW-1:0]  StatusUseMask = 8'h21;
  localparam int unsigned       SyncBit       = 3;
  localparam int unsigned       XSignBit      = 4;
  localparam int unsigned       YSignBit      = 5;
  localparam int unsigned       BtnLeftBit    = 0;
  localparam int unsigned       BtnRightBit   = 1;
  localparam int unsigned       BtnMiddleBit  = 2;

  localparam logic [CoordW-1:0] MaxXReset = 12'd1024;
  localparam logic [CoordW-1:0] MaxYReset = 12'd768;
  localparam logic [CoordW-1:0] PosXReset = 12'd400;
  localparam logic [CoordW-1:0] PosYReset = 12'd300;

  localparam logic [CfgIdxW-1:0] CfgMaxX = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxY = 1'd1;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_X   = 2'd1,
    PH_Y   = 2'd2
  } phase_e;

endpackage

[design/ps2_mouse_packet_cursor.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// Assembles three-byte PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Slave stream: one transaction per controller status / data byte pair.
// Bytes with neither status bit 0 nor bit 5 set are dropped. A packet starts
// only on a byte with bit 3 set. Each completed packet yields one master
// transaction with the clamped cursor, the sign-extended deltas (Y negated,
// screen-down positive) and the three button bits.
// Path: the byte sits in the input register after its accepting edge, and the
// result register loads from it once no held result blocks it, so a packet's
// result follows its third byte through the input and result registers.
// Throughput: one input per cycle unless stalled; one result per packet.
// Stall: a result held by master tready stays put; one more input waits in
// the input register, then slave tready drops.
// Config: cfg_we_i writes max_x (index 0) or max_y (index 1), low 12 bits;
// write only while idle.
// Reset: limits 1024 / 768, cursor 400 / 300, packet phase at the header,
// both registers empty.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ps2mc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ps2mc_pkg::CoordW-1:0]       cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] ctrl_status, [15:8] rx_byte
  input  logic [ps2mc_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [32:24] delta_x, [42:33] delta_y,
  // [43] btn_left, [44] btn_right, [45] btn_middle, [47:46] zero
  output logic [ps2mc_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned CW = ps2mc_pkg::CoordW;
  localparam int unsigned BW = ps2mc_pkg::ByteW;

  logic [CW-1:0] max_x_q, max_y_q;
  logic [CW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [BW-1:0] hdr_q, hdr_d, xb_q, xb_d;
  ps2mc_pkg::phase_e phase_q, phase_d;

  logic                            in_valid_q;
  logic [ps2mc_pkg::InDataW-1:0]   in_data_q;
  logic                            out_valid_q, out_valid_d;
  logic [ps2mc_pkg::OutDataW-1:0]  out_data_q, out_data_d;

  logic          adv;
  logic [BW-1:0] st, rx;
  logic          used;
  logic [ps2mc_pkg::DxW-1:0]  dx;
  logic [ps2mc_pkg::DyW-1:0]  dy;
  logic [ps2mc_pkg::SumW-1:0] sum_x, sum_y;
  logic [CW-1:0] new_x, new_y;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign st   = in_data_q[BW-1:0];
  assign rx   = in_data_q[2*BW-1:BW];
  assign used = in_valid_q && ((st & ps2mc_pkg::StatusUseMask) != '0);

  assign dx = {hdr_q[ps2mc_pkg::XSignBit], xb_q};
  assign dy = ps2mc_pkg::DyW'(-$signed({hdr_q[ps2mc_pkg::YSignBit],
                                        hdr_q[ps2mc_pkg::YSignBit], rx}));

  assign sum_x = {2'b00, pos_x_q} + {{(ps2mc_pkg::SumW-ps2mc_pkg::DxW){dx[ps2mc_pkg::DxW-1]}}, dx};
  assign sum_y = {2'b00, pos_y_q} + {{(ps2mc_pkg::SumW-ps2mc_pkg::DyW){dy[ps2mc_pkg::DyW-1]}}, dy};

  always_comb begin
    if (sum_x[ps2mc_pkg::SumW-1]) begin
      new_x = '0;
    end else if (sum_x[ps2mc_pkg::SumW-2:0] > {1'b0, max_x_q}) begin
      new_x = max_x_q;
    end else begin
      new_x = sum_x[CW-1:0];
    end
    if (sum_y[ps2mc_pkg::SumW-1]) begin
      new_y = '0;
    end else if (sum_y[ps2mc_pkg::SumW-2:0] > {1'b0, max_y_q}) begin
      new_y = max_y_q;
    end else begin
      new_y = sum_y[CW-1:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    xb_d        = xb_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (adv && used) begin
      unique case (phase_q)
        ps2mc_pkg::PH_X: begin
          xb_d    = rx;
          phase_d = ps2mc_pkg::PH_Y;
        end
        ps2mc_pkg::PH_Y: begin
          pos_x_d     = new_x;
          pos_y_d     = new_y;
          phase_d     = ps2mc_pkg::PH_HDR;
          out_valid_d = 1'b1;
          out_data_d  = {2'b00,
                         hdr_q[ps2mc_pkg::BtnMiddleBit],
                         hdr_q[ps2mc_pkg::BtnRightBit],
                         hdr_q[ps2mc_pkg::BtnLeftBit],
                         dy, dx, new_y, new_x};
        end
        default: begin
          phase_d = ps2mc_pkg::PH_HDR;
          if (rx[ps2mc_pkg::SyncBit]) begin
            hdr_d   = rx;
            phase_d = ps2mc_pkg::PH_X;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q     <= ps2mc_pkg::MaxXReset;
      max_y_q     <= ps2mc_pkg::MaxYReset;
      pos_x_q     <= ps2mc_pkg::PosXReset;
      pos_y_q     <= ps2mc_pkg::PosYReset;
      hdr_q       <= '0;
      xb_q        <= '0;
      phase_q     <= ps2mc_pkg::PH_HDR;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ps2mc_pkg::CfgMaxX: max_x_q <= cfg_data_i;
          ps2mc_pkg::CfgMaxY: max_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      hdr_q       <= hdr_d;
      xb_q        <= xb_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_valid_q) && $past(phase_q) == ps2mc_pkg::PH_Y)
    else $error("result without a third packet byte");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule
